/* rtl/hst_pkg.sv */
// ----------------------------------------------------------------------------
// hst_pkg
// shared constants, operation and status codes, and the use-map bit search
// for the handle slot table
// ----------------------------------------------------------------------------
package hst_pkg;

    // default table geometry
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_HANDLE_BASE = 256;

    // slots preset as the standard streams
    localparam int PRESET_SLOTS = 3;
    localparam int PRE_W        = $clog2(PRESET_SLOTS);

    // use map is held as words of this many slot bits
    localparam int MAP_W  = 32;
    localparam int MAP_BW = $clog2(MAP_W);

    // beat field widths
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int KREF_W   = 64;
    localparam int TYPE_W   = 8;
    localparam int FLAGS_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // use-map word 0 after reset: preset slots in use
    localparam logic [MAP_W-1:0] PRESET_MAP = MAP_W'((1 << PRESET_SLOTS) - 1);

    // index of the lowest set bit: isolate it, then encode the one-hot
    function automatic logic [MAP_BW-1:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [MAP_W-1:0]  iso;
        logic [MAP_BW-1:0] idx;
        iso = v & (~v + MAP_W'(1));
        idx = '0;
        for (int b = 0; b < MAP_W; b++)
        begin
            if (iso[b])
            begin
                idx = idx | MAP_BW'(b);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/hst_cfg_if.sv */
// ----------------------------------------------------------------------------
// hst_cfg_if
// configuration write channel: preset type write data
// ----------------------------------------------------------------------------
interface hst_cfg_if;
    import hst_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hst_req_if.sv */
// ----------------------------------------------------------------------------
// hst_req_if
// request channel: one table operation per beat
// ----------------------------------------------------------------------------
interface hst_req_if;
    import hst_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [KREF_W-1:0]   obj_ref;
    logic [TYPE_W-1:0]   res_type;
    logic [FLAGS_W-1:0]  flags;

    modport source (output valid, output kind, output handle, output obj_ref,
                    output res_type, output flags, input ready);
    modport sink   (input valid, input kind, input handle, input obj_ref,
                    input res_type, input flags, output ready);
endinterface

/* rtl/hst_rsp_if.sv */
// ----------------------------------------------------------------------------
// hst_rsp_if
// response channel: one result per request beat
// ----------------------------------------------------------------------------
interface hst_rsp_if;
    import hst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
    logic [KREF_W-1:0]   found_obj_ref;
    logic [TYPE_W-1:0]   found_type;
    logic [FLAGS_W-1:0]  found_flags;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output result_handle,
                    output found_obj_ref, output found_type, output found_flags,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input result_handle,
                    input found_obj_ref, input found_type, input found_flags,
                    input entry_count, output ready);
endinterface

/* rtl/hst_ram.sv */
// ----------------------------------------------------------------------------
// hst_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hst_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/handle_slot_table_unit.sv */
// ----------------------------------------------------------------------------
// handle_slot_table_unit
// fixed table of handle slots with round-robin allocate, free and lookup
// ----------------------------------------------------------------------------
// usage
//   req beat: kind selects allocate, free or lookup; handle names the slot
//     for free and lookup; obj_ref, res_type and flags are stored on
//     allocate. every req beat gives exactly one rsp beat with a status and
//     the live slot count. cfg beats write the type reported for the three
//     preset slots; cfg is always ready, and the user must write cfg only
//     while idle: the block itself does not enforce it.
//   allocate reads w of the 32-slot use-map words before a free slot
//     turns up, w from 1 to ceil(TABLE_DEPTH/32) + 1; the use-map ram port
//     reads one word a cycle. free, lookup and unknown kinds go from idle
//     to execute and then into the rsp register. the block takes one item
//     at a time, and takes the next while the last rsp beat still waits.
//   reset: a clearing pass writes every use-map word with req.ready low;
//     slots 0-2 come out in use, count is 3.
//   stall: a held rsp beat keeps its value; a finished item waits in place
//     until the rsp register is free, then writes its update.
// ----------------------------------------------------------------------------
module handle_slot_table_unit #(
    parameter int TABLE_DEPTH = hst_pkg::DEF_TABLE_DEPTH,
    parameter int HANDLE_BASE = hst_pkg::DEF_HANDLE_BASE
) (
    input  logic      clk,
    input  logic      rst_n,
    hst_cfg_if.sink   cfg,
    hst_req_if.sink   req,
    hst_rsp_if.source rsp
);
    import hst_pkg::*;

    // use-map geometry: a slot index is {word, bit}
    localparam int NWORDS  = (TABLE_DEPTH + MAP_W - 1) / MAP_W;
    localparam int WORD_AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int FULL_W  = WORD_AW + MAP_BW;
    localparam int INC_W   = FULL_W + 1;
    localparam int STEP_W  = $clog2(NWORDS + 1);
    localparam int TAIL    = TABLE_DEPTH % MAP_W;
    localparam int DATA_W  = KREF_W + TYPE_W + FLAGS_W;
    localparam int DEC_W   = HANDLE_W + 1;

    // slots past the table end in the last word count as taken
    localparam logic [MAP_W-1:0]   LAST_MASK  = (TAIL == 0) ? {MAP_W{1'b1}} :
                                                MAP_W'((64'd1 << TAIL) - 64'd1);
    localparam logic [SLOT_W-1:0]  SCAN_RESET = SLOT_W'(HANDLE_BASE % TABLE_DEPTH);
    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(NWORDS - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(NWORDS);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

    // control state
    state_t                     state_reg, state_next;
    logic [WORD_AW-1:0]         clr_word_reg, clr_word_next;
    logic [TYPE_W-1:0]          preset_type_reg, preset_type_next;
    logic [PRESET_SLOTS-1:0]    preset_live_reg, preset_live_next;
    logic [SLOT_W-1:0]          scan_ptr_reg, scan_ptr_next;
    logic [COUNT_W-1:0]         live_count_reg, live_count_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    // item being worked on
    logic [KIND_W-1:0]          kind_reg;
    logic [KREF_W-1:0]          kref_reg;
    logic [TYPE_W-1:0]          rtype_reg;
    logic [FLAGS_W-1:0]         flags_reg;
    logic                       hit_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [WORD_AW-1:0]         cur_word_reg, cur_word_next;

    // rsp payload
    logic [STATUS_W-1:0]        status_reg;
    logic [HANDLE_W-1:0]        rhandle_reg;
    logic [KREF_W-1:0]          fkref_reg;
    logic [TYPE_W-1:0]          ftype_reg;
    logic [FLAGS_W-1:0]         fflags_reg;
    logic [COUNT_W-1:0]         count_reg;

    // ram ports
    logic                       map_we;
    logic [WORD_AW-1:0]         map_waddr, map_raddr;
    logic [MAP_W-1:0]           map_wdata, map_rdata;
    logic                       data_we;
    logic [SLOT_W-1:0]          data_waddr, data_raddr;
    logic [DATA_W-1:0]          data_wdata, data_rdata;

    // handshake
    logic                       accept;
    logic                       out_free;

    // handle decode on the incoming beat
    logic [DEC_W-1:0]           h_ext, diff;
    logic                       dec_hit;
    logic [SLOT_W-1:0]          dec_slot;
    logic [FULL_W-1:0]          dec_full, sp_full;
    logic [WORD_AW-1:0]         start_word, next_word;
    logic [MAP_BW-1:0]          sp_bit;

    // execute stage
    logic [FULL_W-1:0]          slot_full, found_full;
    logic [MAP_BW-1:0]          slot_bit, free_bit;
    logic [MAP_W-1:0]           range_mask, lo_mask, pos_mask, avail;
    logic                       any_free, owned, preset_on;
    logic [SLOT_W-1:0]          found_slot, next_scan;
    logic [INC_W-1:0]           found_inc;
    logic                       alloc_done, done, fire, advance, alloc_ok;

    logic [STATUS_W-1:0]        res_status;
    logic [HANDLE_W-1:0]        res_handle;
    logic [KREF_W-1:0]          res_kref;
    logic [TYPE_W-1:0]          res_type;
    logic [FLAGS_W-1:0]         res_flags;
    logic [COUNT_W-1:0]         res_count;

    // use map: one bit per slot, 32 slots a word
    hst_ram #(
        .WIDTH (MAP_W),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // slot contents: {kernel ref, type, flags}
    hst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // handle to slot: 0-2 map straight, others sit at HANDLE_BASE + slot
    assign h_ext = {1'b0, req.handle};
    assign diff  = h_ext - DEC_W'(HANDLE_BASE);

    always_comb
    begin
        dec_hit  = 1'b0;
        dec_slot = '0;
        if (req.handle < HANDLE_W'(PRESET_SLOTS))
        begin
            dec_hit  = 1'b1;
            dec_slot = SLOT_W'(req.handle);
        end
        else if (h_ext >= DEC_W'(HANDLE_BASE + PRESET_SLOTS) &&
                 diff < DEC_W'(TABLE_DEPTH))
        begin
            dec_hit  = 1'b1;
            dec_slot = diff[SLOT_W-1:0];
        end
    end

    assign dec_full   = FULL_W'(dec_slot);
    assign sp_full    = FULL_W'(scan_ptr_reg);
    assign sp_bit     = sp_full[MAP_BW-1:0];
    assign start_word = (req.kind == KIND_ALLOC) ? sp_full[FULL_W-1:MAP_BW]
                                                 : dec_full[FULL_W-1:MAP_BW];
    assign next_word  = (cur_word_reg == LAST_WORD) ? '0 : cur_word_reg + WORD_AW'(1);

    // free-slot search on the word that just came out of the map ram
    // first word: from the scan pointer up; middle words: all; the start
    // word again at the end: the bits below the scan pointer
    assign range_mask = (cur_word_reg == LAST_WORD) ? LAST_MASK : {MAP_W{1'b1}};
    assign lo_mask    = (MAP_W'(1) << sp_bit) - MAP_W'(1);

    always_comb
    begin
        if (step_reg == '0)
        begin
            pos_mask = ~lo_mask;
        end
        else if (step_reg == LAST_STEP)
        begin
            pos_mask = lo_mask;
        end
        else
        begin
            pos_mask = {MAP_W{1'b1}};
        end
    end

    assign avail      = ~map_rdata & range_mask & pos_mask;
    assign any_free   = |avail;
    assign free_bit   = lowest_set(avail);
    assign found_full = {cur_word_reg, free_bit};
    assign found_slot = found_full[SLOT_W-1:0];
    assign found_inc  = INC_W'(found_full) + INC_W'(1);
    assign next_scan  = (found_inc == INC_W'(TABLE_DEPTH)) ? '0 : found_inc[SLOT_W-1:0];

    // free and lookup need the slot in use
    assign slot_full = FULL_W'(slot_reg);
    assign slot_bit  = slot_full[MAP_BW-1:0];
    assign owned     = hit_reg && map_rdata[slot_bit];
    assign preset_on = (slot_reg < SLOT_W'(PRESET_SLOTS)) &&
                       preset_live_reg[slot_reg[PRE_W-1:0]];

    // an item finishes when its result can go into the rsp register
    assign alloc_done = any_free || (step_reg == LAST_STEP);
    assign done       = (kind_reg != KIND_ALLOC) || alloc_done;
    assign fire       = (state_reg == S_EXEC) && done && out_free;
    assign advance    = (state_reg == S_EXEC) && (kind_reg == KIND_ALLOC) && !alloc_done;
    assign alloc_ok   = fire && (kind_reg == KIND_ALLOC) && any_free;

    // result of the item in execute
    always_comb
    begin
        res_status = ST_NOT_FOUND;
        res_handle = '0;
        res_kref   = '0;
        res_type   = '0;
        res_flags  = '0;
        res_count  = live_count_reg;
        unique case (kind_reg)
            KIND_ALLOC:
            begin
                if (any_free)
                begin
                    res_status = ST_OK;
                    res_handle = (found_slot < SLOT_W'(PRESET_SLOTS)) ?
                                 HANDLE_W'(found_slot) :
                                 HANDLE_W'(HANDLE_BASE) + HANDLE_W'(found_slot);
                    res_count  = live_count_reg + COUNT_W'(1);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            KIND_FREE:
            begin
                if (owned)
                begin
                    res_status = ST_OK;
                    res_count  = (live_count_reg == '0) ? '0
                                                        : live_count_reg - COUNT_W'(1);
                end
            end
            KIND_LOOKUP:
            begin
                if (owned)
                begin
                    res_status = ST_OK;
                    // preset slots report the live preset type until reallocated
                    if (preset_on)
                    begin
                        res_kref = KREF_W'(slot_reg);
                        res_type = preset_type_reg;
                    end
                    else
                    begin
                        res_kref  = data_rdata[DATA_W-1 -: KREF_W];
                        res_type  = data_rdata[FLAGS_W +: TYPE_W];
                        res_flags = data_rdata[FLAGS_W-1:0];
                    end
                end
            end
            default:
            begin
                res_status = ST_NOT_FOUND;
            end
        endcase
    end

    // map ram: reads follow the item, writes come from the clearing pass or
    // from the finishing item; one item at a time keeps a read after its
    // write, so no forwarding is needed
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = cur_word_reg;
        map_wdata = map_rdata;
        if (state_reg == S_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_word_reg;
            map_wdata = (clr_word_reg == '0) ? PRESET_MAP : '0;
        end
        else if (alloc_ok)
        begin
            map_we    = 1'b1;
            map_wdata = map_rdata | (MAP_W'(1) << free_bit);
        end
        else if (fire && (kind_reg == KIND_FREE) && owned)
        begin
            map_we    = 1'b1;
            map_wdata = map_rdata & ~(MAP_W'(1) << slot_bit);
        end
    end

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            map_raddr = start_word;
        end
        else if (advance)
        begin
            map_raddr = next_word;
        end
        else
        begin
            map_raddr = cur_word_reg;
        end
    end

    // data ram: written on allocate only; a freed slot's data is never reported
    // before it is allocated again
    assign data_we    = alloc_ok;
    assign data_waddr = found_slot;
    assign data_wdata = {kref_reg, rtype_reg, flags_reg};
    assign data_raddr = (state_reg == S_IDLE) ? dec_slot : slot_reg;

    // next state
    always_comb
    begin
        state_next       = state_reg;
        clr_word_next    = clr_word_reg;
        preset_type_next = cfg.valid ? cfg.data : preset_type_reg;
        preset_live_next = preset_live_reg;
        scan_ptr_next    = scan_ptr_reg;
        live_count_next  = fire ? res_count : live_count_reg;
        step_next        = step_reg;
        cur_word_next    = cur_word_reg;
        rsp_valid_next   = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_word_next = clr_word_reg + WORD_AW'(1);
                if (clr_word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_EXEC;
                    step_next     = '0;
                    cur_word_next = start_word;
                end
            end
            S_EXEC:
            begin
                if (advance)
                begin
                    step_next     = step_reg + STEP_W'(1);
                    cur_word_next = next_word;
                end
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (alloc_ok)
        begin
            scan_ptr_next = next_scan;
            if (found_slot < SLOT_W'(PRESET_SLOTS))
            begin
                preset_live_next[found_slot[PRE_W-1:0]] = 1'b0;
            end
        end
    end

    // control state and the rsp valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_word_reg    <= '0;
            preset_type_reg <= TYPE_W'(1);
            preset_live_reg <= '1;
            scan_ptr_reg    <= SCAN_RESET;
            live_count_reg  <= COUNT_W'(PRESET_SLOTS);
            step_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_word_reg    <= clr_word_next;
            preset_type_reg <= preset_type_next;
            preset_live_reg <= preset_live_next;
            scan_ptr_reg    <= scan_ptr_next;
            live_count_reg  <= live_count_next;
            step_reg        <= step_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // item and rsp payload
    always_ff @(posedge clk)
    begin
        cur_word_reg <= cur_word_next;
        if (accept)
        begin
            kind_reg  <= req.kind;
            kref_reg  <= req.obj_ref;
            rtype_reg <= req.res_type;
            flags_reg <= req.flags;
            hit_reg   <= dec_hit;
            slot_reg  <= dec_slot;
        end
        if (fire)
        begin
            status_reg  <= res_status;
            rhandle_reg <= res_handle;
            fkref_reg   <= res_kref;
            ftype_reg   <= res_type;
            fflags_reg  <= res_flags;
            count_reg   <= res_count;
        end
    end

    assign rsp.valid               = rsp_valid_reg;
    assign rsp.status              = status_reg;
    assign rsp.result_handle       = rhandle_reg;
    assign rsp.found_obj_ref       = fkref_reg;
    assign rsp.found_type          = ftype_reg;
    assign rsp.found_flags         = fflags_reg;
    assign rsp.entry_count         = count_reg;

`ifndef SYNTHESIS
    // the live count can never pass the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("live count above table depth");

    // a full table means every slot is counted as live
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> rsp.entry_count == COUNT_W'(TABLE_DEPTH))
        else $error("table full reported with free slots counted");

    // an accepted beat always moves into execute
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted beat did not enter execute");

    // slot data is only written together with its use-map bit
    a_data_with_map: assert property (@(posedge clk) disable iff (!rst_n)
        data_we |-> map_we && (map_waddr == cur_word_reg) && (state_reg == S_EXEC))
        else $error("slot data written without use-map update");
`endif

endmodule
